### rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants for the sequential list engine: operation codes,
// controller states, the result record and the store command bundle.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 128;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned OP_W           = 3;
  localparam int unsigned POS_W          = 8;
  localparam int unsigned LEN_W          = 8;
  localparam int unsigned S_TDATA_W      = 48;
  localparam int unsigned M_TDATA_W      = 48;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 3'd0,
    OP_LOCATE = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LOCATE,
    S_INSERT,
    S_DELETE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic                     found;
    logic [LEN_W-1:0]         list_length;
  } res_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_cmd_t;

endpackage

### rtl/sle_store.sv
// ----------------------------------------------------------------------------
// sle_store
// Entry memory of the list: one write port and one read port with a
// registered read. Contents are undefined until written.
// ----------------------------------------------------------------------------
module sle_store import sle_pkg::*; #(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF,
  parameter int unsigned AW         = $clog2(LIST_DEPTH)
) (
  input  logic                     clk_i,
  input  store_cmd_t               cmd_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic signed [DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]            raddr_i,
  output logic signed [DATA_W-1:0] rdata_o
);

  logic signed [DATA_W-1:0] mem [LIST_DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sle_ctrl.sv
// ----------------------------------------------------------------------------
// sle_ctrl
// Operation sequencer. Holds the entry count, walks the store one entry per
// cycle for locate, insert and delete, and builds the result record.
// ----------------------------------------------------------------------------
module sle_ctrl import sle_pkg::*; #(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF,
  parameter int unsigned AW         = $clog2(LIST_DEPTH),
  parameter int unsigned CW         = $clog2(LIST_DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [OP_W-1:0]          in_op_i,
  input  logic [POS_W-1:0]         in_pos_i,
  input  logic signed [DATA_W-1:0] in_val_i,
  output store_cmd_t               cmd_o,
  output logic [AW-1:0]            waddr_o,
  output logic signed [DATA_W-1:0] wdata_o,
  output logic [AW-1:0]            raddr_o,
  input  logic signed [DATA_W-1:0] rdata_i,
  output logic                     res_valid_o,
  output res_t                     res_o,
  input  logic                     res_taken_i
);

  // Comparison width wide enough for both a position and a count plus one.
  localparam int unsigned PW = ((CW > POS_W) ? CW : POS_W) + 1;

  state_e                   state_q, state_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [CW-1:0]            ptr_q, ptr_d;
  logic [AW-1:0]            tag_q, tag_d;
  logic                     rvalid_q, rvalid_d;
  logic                     first_q, first_d;
  logic [POS_W-1:0]         pos_q, pos_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  res_t                     res_q, res_d;

  logic [PW-1:0] pos_in_ext, pos_q_ext, cnt_ext, ptr_ext;

  assign pos_in_ext = PW'(in_pos_i);
  assign pos_q_ext  = PW'(pos_q);
  assign cnt_ext    = PW'(cnt_q);
  assign ptr_ext    = PW'(ptr_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    tag_d       = tag_q;
    rvalid_d    = 1'b0;
    first_d     = first_q;
    pos_d       = pos_q;
    val_d       = val_q;
    res_d       = res_q;
    cmd_o       = '0;
    waddr_o     = '0;
    wdata_o     = rdata_i;
    raddr_o     = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          pos_d   = in_pos_i;
          val_d   = in_val_i;
          res_d   = '{ok: 1'b0, read_value: '0, found: 1'b0, list_length: LEN_W'(cnt_q)};
          state_d = S_DONE;
          unique case (op_e'(in_op_i))
            OP_READ: begin
              if (in_pos_i != '0 && pos_in_ext <= cnt_ext) begin
                cmd_o.rd_en = 1'b1;
                raddr_o     = AW'(pos_in_ext - PW'(1));
                state_d     = S_READ;
              end
            end
            OP_LOCATE: begin
              if (cnt_q == '0) begin
                res_d.ok = 1'b1;
              end else begin
                ptr_d   = '0;
                state_d = S_LOCATE;
              end
            end
            OP_INSERT: begin
              if (in_pos_i != '0 && pos_in_ext <= cnt_ext + PW'(1) &&
                  cnt_q != CW'(LIST_DEPTH)) begin
                ptr_d   = cnt_q;
                state_d = S_INSERT;
              end
            end
            OP_DELETE: begin
              if (in_pos_i != '0 && pos_in_ext <= cnt_ext) begin
                ptr_d   = CW'(pos_in_ext - PW'(1));
                first_d = 1'b1;
                state_d = S_DELETE;
              end
            end
            OP_CLEAR: begin
              cnt_d             = '0;
              res_d.ok          = 1'b1;
              res_d.list_length = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_READ: begin
        res_d.ok         = 1'b1;
        res_d.read_value = rdata_i;
        state_d          = S_DONE;
      end

      // Reads run one ahead of the compares; a hit or the last compare ends it.
      S_LOCATE: begin
        if (ptr_q < cnt_q) begin
          cmd_o.rd_en = 1'b1;
          raddr_o     = AW'(ptr_q);
          ptr_d       = ptr_q + CW'(1);
          rvalid_d    = 1'b1;
        end
        if (rvalid_q && (rdata_i == val_q || ptr_q == cnt_q)) begin
          res_d.ok    = 1'b1;
          res_d.found = (rdata_i == val_q);
          rvalid_d    = 1'b0;
          state_d     = S_DONE;
        end
      end

      // Tail moves up from the top: read entry j-1, and the registered word is written to j.
      S_INSERT: begin
        if (rvalid_q) begin
          cmd_o.wr_en = 1'b1;
          waddr_o     = tag_q;
          wdata_o     = rdata_i;
        end
        if (ptr_ext >= pos_q_ext) begin
          cmd_o.rd_en = 1'b1;
          raddr_o     = AW'(ptr_q - CW'(1));
          tag_d       = AW'(ptr_q);
          ptr_d       = ptr_q - CW'(1);
          rvalid_d    = 1'b1;
        end else if (!rvalid_q) begin
          cmd_o.wr_en       = 1'b1;
          waddr_o           = AW'(pos_q_ext - PW'(1));
          wdata_o           = val_q;
          cnt_d             = cnt_q + CW'(1);
          res_d.ok          = 1'b1;
          res_d.list_length = LEN_W'(cnt_q + CW'(1));
          state_d           = S_DONE;
        end
      end

      // The first read returns the removed entry; later ones move down by one.
      S_DELETE: begin
        if (rvalid_q) begin
          if (first_q) begin
            res_d.read_value = rdata_i;
            first_d          = 1'b0;
          end else begin
            cmd_o.wr_en = 1'b1;
            waddr_o     = tag_q - AW'(1);
            wdata_o     = rdata_i;
          end
        end
        if (ptr_q < cnt_q) begin
          cmd_o.rd_en = 1'b1;
          raddr_o     = AW'(ptr_q);
          tag_d       = AW'(ptr_q);
          ptr_d       = ptr_q + CW'(1);
          rvalid_d    = 1'b1;
        end else if (!rvalid_q) begin
          cnt_d             = cnt_q - CW'(1);
          res_d.ok          = 1'b1;
          res_d.list_length = LEN_W'(cnt_q - CW'(1));
          state_d           = S_DONE;
        end
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_taken_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      rvalid_q <= 1'b0;
      first_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rvalid_q <= rvalid_d;
      first_q  <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    tag_q <= tag_d;
    pos_q <= pos_d;
    val_q <= val_d;
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

### rtl/sequential_list_engine.sv
// ----------------------------------------------------------------------------
// sequential_list_engine
// Ordered list of signed 32-bit words held in a single memory, with read,
// locate, insert, delete and clear operations on 1-based positions.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Signals                          Contents
//   s_axis   in   tvalid / tready / tdata[47:0]    operation, position, item_value
//   m_axis   out  tvalid / tready / tdata[47:0]    ok, read_value, found, list_length
//
// Each transfer in produces exactly one transfer out, in order.
// Clear, a rejected operation and an empty locate go straight to the result;
// read waits for the registered memory word. Locate walks up to all n
// entries of the list, insert and delete the entries from the position to
// the end; the slowest is a delete at position 1 of a full list. The next
// operation can be taken in the cycle after the result moves on. The walk
// over the list uses the single memory read port one entry per cycle.
// Reset clears the entry count and the control state; the memory keeps
// whatever it holds and needs no clearing pass.
// A stalled output holds its result in the output register, and the engine
// still takes and starts the next operation; only its result waits.
//
module sequential_list_engine import sle_pkg::*; #(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [2:0] operation, [10:3] position, [42:11] item_value, [47:43] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] ok, [32:1] read_value, [33] found, [41:34] list_length, [47:42] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  store_cmd_t               store_cmd;
  logic [AW-1:0]            store_waddr;
  logic [AW-1:0]            store_raddr;
  logic signed [DATA_W-1:0] store_wdata;
  logic signed [DATA_W-1:0] store_rdata;

  logic res_valid;
  res_t res;

  // Output register: parts the result side from the sequencer.
  logic m_valid_q, m_valid_d;
  res_t m_res_q, m_res_d;
  logic out_free;
  logic out_load;

  sle_store #(
    .LIST_DEPTH (LIST_DEPTH),
    .AW         (AW)
  ) u_store (
    .clk_i   (clk_i),
    .cmd_i   (store_cmd),
    .waddr_i (store_waddr),
    .wdata_i (store_wdata),
    .raddr_i (store_raddr),
    .rdata_o (store_rdata)
  );

  sle_ctrl #(
    .LIST_DEPTH (LIST_DEPTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tdata[2:0]),
    .in_pos_i    (s_axis_tdata[10:3]),
    .in_val_i    (s_axis_tdata[42:11]),
    .cmd_o       (store_cmd),
    .waddr_o     (store_waddr),
    .wdata_o     (store_wdata),
    .raddr_o     (store_raddr),
    .rdata_i     (store_rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_taken_i (out_free)
  );

  // The register takes a new result when it is empty or being drained.
  assign out_free = !m_valid_q || m_axis_tready;
  assign out_load = res_valid && out_free;

  always_comb begin
    m_res_d   = m_res_q;
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_res_d   = res;
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_res_q <= m_res_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, m_res_q.list_length, m_res_q.found,
                          m_res_q.read_value, m_res_q.ok};

  // An accepted operation always leaves the idle state, so the engine is not ready in the next cycle.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("engine ready again right after accepting an operation");

  // A finished result waits in the sequencer until the output register frees.
  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !out_free |=> res_valid)
    else $error("result dropped while output register was full");

  // The shifting walks never read and write the same entry in one cycle.
  a_no_rw_collision : assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_cmd.wr_en && store_cmd.rd_en |-> store_waddr != store_raddr)
    else $error("memory read and write hit the same entry");

  // A rejected operation reports neither data nor a hit.
  a_reject_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[33:1] == '0)
    else $error("rejected result carries data");

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sequential_list_engine. A shadow copy of the list
// predicts every result, and results are checked field by field in order.
// A short directed part is followed by random phases that grow, shrink and
// mix the list or send noise. Both stream sides idle at random, and the
// receiver holds off twice for a long stretch so that the engine backs up.
// ----------------------------------------------------------------------------
module testbench;
  import sle_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = LIST_DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned IDLE_LIMIT   = 4000;  // cycles without any transfer
  localparam int unsigned HOLD_CYCLES  = 600;   // long receiver hold-off
  localparam int unsigned HOLD_FIRST   = 400;   // result counts that start one
  localparam int unsigned HOLD_SECOND  = 1300;
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 20;

  // Operation codes that the engine does not define and must reject.
  localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  // Flavors of random phase.
  typedef enum int unsigned {
    MIX_GROW,
    MIX_SHRINK,
    MIX_BALANCED,
    MIX_NOISE
  } mix_e;

  // --------------------------------------------------------------------------
  // Shadow list: keeps its own copy of the entries and the length, works out
  // the result of every accepted operation and queues it until the engine
  // delivers the matching result.
  // --------------------------------------------------------------------------
  class list_shadow;
    logic signed [DATA_W-1:0] entries [DEPTH];
    int unsigned              entry_count = 0;
    res_t                     awaited [$];
    int unsigned              errors = 0;
    int unsigned              checked = 0;

    function int unsigned length();
      return entry_count;
    endfunction

    function logic signed [DATA_W-1:0] entry(int unsigned idx);
      return entries[idx];
    endfunction

    // Applies one accepted operation to the shadow and queues its result.
    function void note_operation(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                 logic signed [DATA_W-1:0] val);
      res_t        want;
      int unsigned n;
      int unsigned p;
      want = '0;
      n    = entry_count;
      p    = 32'(pos);
      case (op)
        OP_READ: begin
          if (p >= 1 && p <= n) begin
            want.ok         = 1'b1;
            want.read_value = entries[p-1];
          end
        end
        OP_LOCATE: begin
          want.ok = 1'b1;
          for (int unsigned j = 0; j < n; j++) begin
            if (entries[j] == val) want.found = 1'b1;
          end
        end
        OP_INSERT: begin
          // Rejected when the position is outside 1..n+1 or the list is full.
          if (p >= 1 && p <= n + 1 && n < DEPTH) begin
            for (int j = n; j >= int'(p); j--) entries[j] = entries[j-1];
            entries[p-1] = val;
            n++;
            want.ok = 1'b1;
          end
        end
        OP_DELETE: begin
          // The removed entry is returned, not the one that slides into its place.
          if (p >= 1 && p <= n) begin
            want.read_value = entries[p-1];
            for (int unsigned j = p; j < n; j++) entries[j-1] = entries[j];
            n--;
            want.ok = 1'b1;
          end
        end
        OP_CLEAR: begin
          n       = 0;
          want.ok = 1'b1;
        end
        default: begin
        end
      endcase
      entry_count      = n;
      want.list_length = n[LEN_W-1:0];
      awaited.push_back(want);
    endfunction

    task report(string what, logic [DATA_W-1:0] want_v, logic [DATA_W-1:0] got_v);
      $display("%0t: result %0d: %s: expected %h, got %h",
               $time, checked, what, want_v, got_v);
      errors++;
    endtask

    // Compares one result taken from the engine with the oldest expectation.
    task check_result(logic [M_TDATA_W-1:0] word);
      res_t got;
      res_t want;
      got.ok          = word[0];
      got.read_value  = word[32:1];
      got.found       = word[33];
      got.list_length = word[41:34];
      if (awaited.size() == 0) begin
        report("result with no operation outstanding", '0, word[DATA_W-1:0]);
      end else begin
        want = awaited.pop_front();
        if (got.ok !== want.ok) report("ok", DATA_W'(want.ok), DATA_W'(got.ok));
        if (got.read_value !== want.read_value) begin
          report("read_value", want.read_value, got.read_value);
        end
        if (got.found !== want.found) begin
          report("found", DATA_W'(want.found), DATA_W'(got.found));
        end
        if (got.list_length !== want.list_length) begin
          report("list_length", DATA_W'(want.list_length), DATA_W'(got.list_length));
        end
      end
      checked++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the engine.
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // [2:0] operation, [10:3] position, [42:11] item_value, [47:43] zero
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // [0] ok, [32:1] read_value, [33] found, [41:34] list_length, [47:42] zero
  logic [M_TDATA_W-1:0] m_axis_tdata;

  list_shadow  shadow;
  bit          sender_burst = 1'b0;  // when set, the sender offers back to back
  bit          sink_burst   = 1'b0;  // when set, the receiver stalls only for the long hold-off
  int unsigned results_seen = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  sequential_list_engine #(
    .LIST_DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // --------------------------------------------------------------------------
  // Sender side. The task is entered at a falling edge and leaves at one, so
  // every input change falls on a falling edge. A random gap lowers tvalid
  // first; with no gap the next item follows the previous transfer directly.
  // The shadow is updated right at the accepting edge, so the next item can
  // be shaped from the list as it stands after every earlier operation.
  // --------------------------------------------------------------------------
  task automatic send_item(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                           logic signed [DATA_W-1:0] val);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W - 43){1'b0}}, val, pos, op};
    do @(posedge clk_i); while (!s_axis_tready);
    shadow.note_operation(op, pos, val);
    @(negedge clk_i);
  endtask

  // Draws one random operation. Apart from noise, most positions fall inside
  // the list and many located values are taken from it, so that the walks
  // over the list and the shifts actually run; the rest probe the borders.
  function automatic void pick_item(mix_e mix, output logic [OP_W-1:0] op,
                                    output logic [POS_W-1:0] pos,
                                    output logic signed [DATA_W-1:0] val);
    int unsigned n;
    int unsigned r;
    int unsigned hi;
    int unsigned w_ins;
    int unsigned w_del;
    int unsigned w_rd;
    int unsigned w_loc;
    n = shadow.length();
    if (mix == MIX_NOISE) begin
      op  = OP_W'($urandom_range(0, 7));
      pos = POS_W'($urandom_range(0, 255));
      val = $urandom;
      return;
    end
    case (mix)
      MIX_GROW:   begin w_ins = 65; w_del = 10; w_rd = 10; w_loc = 12; end
      MIX_SHRINK: begin w_ins = 10; w_del = 60; w_rd = 12; w_loc = 15; end
      default:    begin w_ins = 30; w_del = 30; w_rd = 18; w_loc = 18; end
    endcase
    r = $urandom_range(0, 99);
    if (r < w_ins) op = OP_INSERT;
    else if (r < w_ins + w_del) op = OP_DELETE;
    else if (r < w_ins + w_del + w_rd) op = OP_READ;
    else if (r < w_ins + w_del + w_rd + w_loc) op = OP_LOCATE;
    // A growing phase never clears, so that it reaches a full list.
    else if (mix != MIX_GROW && r < 99) op = OP_CLEAR;
    else op = OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));

    hi = (op == OP_INSERT) ? n + 1 : n;
    if ($urandom_range(0, 99) < 85 && hi >= 1) begin
      pos = POS_W'($urandom_range(1, hi));
    end else begin
      case ($urandom_range(0, 3))
        0:       pos = 0;
        1:       pos = POS_W'(hi + 1);
        2:       pos = 255;
        default: pos = POS_W'($urandom_range(0, 255));
      endcase
    end

    r = $urandom_range(0, 99);
    if (r < 35 && n > 0) begin
      val = shadow.entry($urandom_range(0, n - 1));
    end else if (r < 55) begin
      case ($urandom_range(0, 4))
        0:       val = VAL_MIN;
        1:       val = VAL_MAX;
        2:       val = -1;
        3:       val = 1;
        default: val = 0;
      endcase
    end else begin
      val = $urandom;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Receiver side. It draws a stall for every result and checks each result
  // at the edge where it is taken. Twice it holds tready low for a long
  // stretch while the sender keeps offering, which fills the engine and
  // must stall its input without losing or reordering anything.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (results_seen == HOLD_FIRST || results_seen == HOLD_SECOND) begin
        stall = HOLD_CYCLES;
      end else begin
        stall = sink_burst ? 0 : $urandom_range(0, 14);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      shadow.check_result(m_axis_tdata);
      results_seen++;
      if (results_seen % 64 == 0) sink_burst = ($urandom_range(0, 3) == 0);
      @(negedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run when no transfer happens on either side for too
  // long. The limit sits well above the slowest operation plus both stalls
  // and above the long receiver hold-off.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    wait (rst_ni === 1'b1);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("sequential_list_engine: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus: reset, a directed pass over the special cases, then random
  // phases, then a drain before the verdict.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    mix_e                     mix;
    int unsigned              phase_len;
    int unsigned              sent;
    int unsigned              r;
    shadow        = new;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Everything is rejected or empty on a fresh list.
    send_item(OP_READ,   8'd1, 32'sd0);
    send_item(OP_DELETE, 8'd1, 32'sd0);
    send_item(OP_LOCATE, 8'd0, 32'sd0);
    // Insert at position zero and two past the end are bad positions.
    send_item(OP_INSERT, 8'd0, 32'sd5);
    send_item(OP_INSERT, 8'd2, 32'sd5);
    // Build -1, 0, max, min by inserting at the head, the tail and the middle.
    send_item(OP_INSERT, 8'd1, VAL_MAX);
    send_item(OP_INSERT, 8'd2, VAL_MIN);
    send_item(OP_INSERT, 8'd1, -32'sd1);
    send_item(OP_INSERT, 8'd2, 32'sd0);
    send_item(OP_INSERT, 8'd6, 32'sd7);
    send_item(OP_READ,   8'd4, 32'sd0);
    send_item(OP_READ,   8'd5, 32'sd0);
    send_item(OP_READ,   8'd255, VAL_MAX);
    send_item(OP_LOCATE, 8'd0, VAL_MIN);
    send_item(OP_LOCATE, 8'd255, 32'sd12345);
    // Delete from the middle, then the tail, then at position zero.
    send_item(OP_DELETE, 8'd2, 32'sd0);
    send_item(OP_DELETE, 8'd3, 32'sd0);
    send_item(OP_DELETE, 8'd0, 32'sd0);
    // Undefined operation codes are rejected and leave the list alone.
    send_item(OP_RSVD_FIRST,        8'd1, 32'sd0);
    send_item(OP_RSVD_FIRST + 3'd1, 8'd1, VAL_MIN);
    send_item(OP_RSVD_LAST,         8'd255, -32'sd1);
    // Clear keeps the stored words, but a locate must not see them any more.
    send_item(OP_CLEAR,  8'd0, 32'sd0);
    send_item(OP_READ,   8'd1, 32'sd0);
    send_item(OP_INSERT, 8'd1, 32'sh5A5A_5A5A);
    send_item(OP_LOCATE, 8'd1, VAL_MAX);

    // The first random phase grows the list until inserts hit a full list.
    sent      = 0;
    mix       = MIX_GROW;
    phase_len = 350;
    while (sent < RANDOM_ITEMS) begin
      sender_burst = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        pick_item(mix, op, pos, val);
        send_item(op, pos, val);
        sent++;
      end
      r = $urandom_range(0, 6);
      if (r < 2) mix = MIX_GROW;
      else if (r < 4) mix = MIX_SHRINK;
      else if (r < 6) mix = MIX_BALANCED;
      else mix = MIX_NOISE;
      phase_len = $urandom_range(50, 250);
      // The last phase stops at the planned number of items.
      if (sent < RANDOM_ITEMS && phase_len > RANDOM_ITEMS - sent) begin
        phase_len = RANDOM_ITEMS - sent;
      end
    end
    s_axis_tvalid <= 1'b0;

    // Wait for every outstanding result, then give a stray one time to show.
    while (shadow.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (shadow.errors == 0) begin
      $display("sequential_list_engine: match");
    end else begin
      $display("sequential_list_engine: mismatch");
    end
    $finish;
  end

endmodule
